FILE: design/glte_pkg.sv
// shared types, constants and helpers of the glyph lookup table engine
package glte_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int QUEUE_DEPTH = 2;

  localparam int FMT_W   = 3;
  localparam int ECOUNT_W = 11;
  localparam int GLYPH_W = 16;
  localparam int VALUE_W = 16;
  localparam int INDEX_W = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [FMT_W-1:0] FMT_SIMPLE  = 3'd0;
  localparam logic [FMT_W-1:0] FMT_SEG_ONE = 3'd1;
  localparam logic [FMT_W-1:0] FMT_SEG_ARR = 3'd2;
  localparam logic [FMT_W-1:0] FMT_SINGLE  = 3'd3;
  localparam logic [FMT_W-1:0] FMT_TRIMMED = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM   = 2'd2;

  typedef struct packed {
    logic                      mode;
    logic [INDEX_W-1:0]        entry_index;
    logic [GLYPH_W-1:0]        key_first;
    logic [GLYPH_W-1:0]        key_last;
    logic signed [VALUE_W-1:0] entry_value;
    logic [GLYPH_W-1:0]        query_glyph;
  } glte_in_t;

  typedef struct packed {
    logic                      found;
    logic signed [VALUE_W-1:0] result_value;
    logic [GLYPH_W-1:0]        segment_first;
    logic                      first_valid;
  } glte_out_t;

  typedef struct packed {
    logic [FMT_W-1:0]    table_format;
    logic [ECOUNT_W-1:0] entry_count;
    logic [GLYPH_W-1:0]  trimmed_first_glyph;
  } glte_cfg_t;

  typedef struct packed {
    logic [GLYPH_W-1:0]        first;
    logic [GLYPH_W-1:0]        last;
    logic signed [VALUE_W-1:0] value;
  } glte_entry_t;

  localparam int ENTRY_W = $bits(glte_entry_t);

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_DIRECT = 2'd1,
    OP_SEARCH = 2'd2,
    OP_MISS   = 2'd3
  } glte_op_t;

  typedef struct packed {
    glte_op_t           op;
    logic               seg;
    logic               want_first;
    logic [ADDR_W-1:0]  addr;
    logic [CNT_W-1:0]   span;
    logic [GLYPH_W-1:0] glyph;
    glte_entry_t        entry;
  } glte_item_t;

  function automatic logic [CNT_W-1:0] used_count(input logic [ECOUNT_W-1:0] count);
    if (32'(count) > TABLE_DEPTH) begin
      return CNT_W'(TABLE_DEPTH);
    end
    return CNT_W'(count);
  endfunction

endpackage

FILE: design/glte_ram.sv
// generic simple dual port ram with registered read
module glte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/glte_front.sv
// front end: accepts transactions, classifies them and hands them to the queue
module glte_front
  import glte_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  glte_cfg_t  cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  glte_in_t   in_data,
  output logic       q_wr_valid,
  input  logic       q_wr_ready,
  output glte_item_t q_wr_data
);

  logic       hold_valid_r, hold_valid_nxt;
  glte_item_t hold_r, hold_nxt;
  glte_item_t cls;
  logic       keep;
  logic       push;
  logic       accept;
  logic [CNT_W-1:0]   used;
  logic [GLYPH_W-1:0] off;

  assign used = used_count(cfg.entry_count);
  assign off  = in_data.query_glyph - cfg.trimmed_first_glyph;

  always_comb begin
    cls            = '0;
    cls.glyph      = in_data.query_glyph;
    cls.span       = used;
    cls.entry      = '{first: in_data.key_first, last: in_data.key_last,
                       value: in_data.entry_value};
    keep           = 1'b1;
    if (!in_data.mode) begin
      cls.op = OP_LOAD;
      cls.addr = ADDR_W'(in_data.entry_index);
      keep = (32'(in_data.entry_index) < TABLE_DEPTH);
    end else begin
      cls.op = OP_MISS;
      unique case (cfg.table_format) inside
        FMT_SIMPLE: begin
          if (32'(in_data.query_glyph) < 32'(used)) begin
            cls.op   = OP_DIRECT;
            cls.addr = ADDR_W'(in_data.query_glyph);
          end
        end
        FMT_SEG_ONE, FMT_SEG_ARR: begin
          cls.op         = OP_SEARCH;
          cls.seg        = 1'b1;
          cls.want_first = (cfg.table_format == FMT_SEG_ARR);
        end
        FMT_SINGLE: begin
          cls.op = OP_SEARCH;
        end
        FMT_TRIMMED: begin
          if (in_data.query_glyph >= cfg.trimmed_first_glyph &&
              32'(off) < 32'(used)) begin
            cls.op   = OP_DIRECT;
            cls.addr = ADDR_W'(off);
          end
        end
        default: cls.op = OP_MISS;
      endcase
    end
  end

  assign push     = hold_valid_r && q_wr_ready;
  assign in_ready = !hold_valid_r || q_wr_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    hold_valid_nxt = (hold_valid_r && !push) || (accept && keep);
    hold_nxt       = accept ? cls : hold_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
    hold_r <= hold_nxt;
  end

  assign q_wr_valid = hold_valid_r;
  assign q_wr_data  = hold_r;

endmodule

FILE: design/glte_fifo.sv
// short queue between the front end and the back end
module glte_fifo
  import glte_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_valid,
  output logic       wr_ready,
  input  glte_item_t wr_data,
  output logic       rd_valid,
  input  logic       rd_ready,
  output glte_item_t rd_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  glte_item_t slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic do_wr, do_rd;

  assign wr_ready = (32'(count_r) < QUEUE_DEPTH);
  assign rd_valid = (count_r != '0);
  assign rd_data  = slot_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: design/glte_back.sv
// back end: table writes, direct reads, binary search and the output register
module glte_back
  import glte_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  output logic       q_ready,
  input  glte_item_t q_data,
  output logic       out_valid,
  input  logic       out_ready,
  output glte_out_t  out_data
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_CMP   = 4'b0100,
    ST_DONE  = 4'b1000
  } back_state_t;

  back_state_t state_r, state_nxt;
  logic [CNT_W-1:0]   lo_r, lo_nxt, hi_r, hi_nxt;
  logic [ADDR_W-1:0]  mid_r, mid_nxt;
  logic               seg_r, seg_nxt;
  logic               want_first_r, want_first_nxt;
  logic [GLYPH_W-1:0] glyph_r, glyph_nxt;
  glte_out_t          res_r, res_nxt;
  glte_out_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               wr_en, rd_en;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  glte_entry_t        wr_data, rd_data;
  logic [GLYPH_W-1:0] high_key;
  logic               below, above;
  logic [CNT_W-1:0]   lo_new, hi_new;
  logic [CNT_W:0]     sum_first, sum_new;

  glte_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign high_key  = seg_r ? rd_data.last : rd_data.first;
  assign below     = glyph_r < rd_data.first;
  assign above     = high_key < glyph_r;
  assign lo_new    = (above && !below) ? CNT_W'(mid_r) + 1'b1 : lo_r;
  assign hi_new    = below ? CNT_W'(mid_r) : hi_r;
  assign sum_first = {1'b0, q_data.span};
  assign sum_new   = {1'b0, lo_new} + {1'b0, hi_new};

  always_comb begin
    state_nxt      = state_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    seg_nxt        = seg_r;
    want_first_nxt = want_first_r;
    glyph_nxt      = glyph_r;
    res_nxt        = res_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    q_ready        = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = q_data.addr;
    wr_data        = q_data.entry;
    rd_en          = 1'b0;
    rd_addr        = q_data.addr;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_ready = 1'b1;
          unique case (q_data.op)
            OP_LOAD: begin
              wr_en = 1'b1;
            end
            OP_DIRECT: begin
              rd_en     = 1'b1;
              state_nxt = ST_FETCH;
            end
            OP_SEARCH: begin
              seg_nxt        = q_data.seg;
              want_first_nxt = q_data.want_first;
              glyph_nxt      = q_data.glyph;
              lo_nxt         = '0;
              hi_nxt         = q_data.span;
              if (q_data.span != '0) begin
                mid_nxt   = sum_first[ADDR_W:1];
                rd_addr   = sum_first[ADDR_W:1];
                rd_en     = 1'b1;
                state_nxt = ST_CMP;
              end else begin
                res_nxt   = '0;
                state_nxt = ST_DONE;
              end
            end
            OP_MISS: begin
              res_nxt   = '0;
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_FETCH: begin
        res_nxt              = '0;
        res_nxt.found        = 1'b1;
        res_nxt.result_value = rd_data.value;
        state_nxt            = ST_DONE;
      end
      ST_CMP: begin
        if (!below && !above) begin
          res_nxt.found         = 1'b1;
          res_nxt.result_value  = rd_data.value;
          res_nxt.segment_first = want_first_r ? rd_data.first : '0;
          res_nxt.first_valid   = want_first_r;
          state_nxt             = ST_DONE;
        end else begin
          lo_nxt = lo_new;
          hi_nxt = hi_new;
          if (lo_new < hi_new) begin
            mid_nxt = sum_new[ADDR_W:1];
            rd_addr = sum_new[ADDR_W:1];
            rd_en   = 1'b1;
          end else begin
            res_nxt   = '0;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    seg_r        <= seg_nxt;
    want_first_r <= want_first_nxt;
    glyph_r      <= glyph_nxt;
    res_r        <= res_nxt;
    out_r        <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_range_open: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CMP |-> lo_r < hi_r)
    else $error("search range empty while probing");

  a_probe_inside: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CMP |-> (CNT_W'(mid_r) >= lo_r && CNT_W'(mid_r) < hi_r))
    else $error("probe address outside search range");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_ready |-> state_r == ST_IDLE)
    else $error("queue popped while busy");

  a_first_needs_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.first_valid |-> out_r.found)
    else $error("first glyph flagged on a miss");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.found |-> (out_r.result_value == '0 &&
                                     out_r.segment_first == '0))
    else $error("miss carries nonzero payload");

endmodule

FILE: design/glyph_lookup_table_engine_unit.sv
// top level of the glyph lookup table engine: config registers, front end, queue, back end
//
//   channel   direction   handshake              payload
//   in_       input       in_valid / in_ready    in_data (glte_in_t)
//   out_      output      out_valid / out_ready  out_data (glte_out_t)
//   cfg_      input       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// the back end runs one transaction at a time; a load only writes the table, a simple
// or trimmed hit does one direct read, a lookup missed without a read does none, and a
// search lookup does at most floor(log2(entry_count)) + 1 table reads (eleven for 1024
// entries)
// the front register and the two entry queue buffer transactions and keep accepting
// while the back end or the output register is stalled, until all three slots are full
// reset is synchronous; the table has no clearing pass and holds garbage until loaded
module glyph_lookup_table_engine_unit
  import glte_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  glte_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output glte_out_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  glte_cfg_t  cfg_r, cfg_nxt;
  logic       q_wr_valid, q_wr_ready;
  glte_item_t q_wr_data;
  logic       q_rd_valid, q_rd_ready;
  glte_item_t q_rd_data;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FORMAT: cfg_nxt.table_format        = cfg_data[FMT_W-1:0];
        REG_COUNT:  cfg_nxt.entry_count         = cfg_data[ECOUNT_W-1:0];
        REG_TRIM:   cfg_nxt.trimmed_first_glyph = cfg_data[GLYPH_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  glte_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_wr_valid (q_wr_valid),
    .q_wr_ready (q_wr_ready),
    .q_wr_data  (q_wr_data)
  );

  glte_fifo u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_data  (q_wr_data),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready),
    .rd_data  (q_rd_data)
  );

  glte_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_rd_valid),
    .q_ready   (q_rd_ready),
    .q_data    (q_rd_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
